// File: rtl/core/snp_pkg.sv
// shared types and constants for the segment nearest point unit
package snp_pkg;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_END_X   = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_END_Y   = 2'd3;

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_END      = 2'd1,
        REGION_INTERIOR = 2'd2
    } t_region;

endpackage

// File: rtl/core/snp_div.sv
// pipelined restoring divider, one quotient bit per stage
module snp_div #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [3*COORD_WIDTH:0]     i_num,
    input  logic [2*COORD_WIDTH:0]     i_den,
    output logic [COORD_WIDTH-1:0]     o_quo
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = 2 * COORD_WIDTH + 1;
    localparam int NW = 3 * COORD_WIDTH + 1;

    logic [DW-1:0] r_rem [CW];
    logic [CW-1:0] r_low [CW];
    logic [CW-1:0] r_quo [CW];
    logic [DW-1:0] n_rem [CW];
    logic [CW-1:0] n_low [CW];
    logic [CW-1:0] n_quo [CW];

    genvar k;
    generate
        for (k = 0; k < CW; k++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [CW-1:0] low_in;
            logic [CW-1:0] quo_in;
            logic [DW:0]   trial;
            logic          fits;

            if (k == 0) begin : g_first
                // quotient stays below 2^CW, so the top part is already below the divisor
                assign rem_in = i_num[NW-1:CW];
                assign low_in = i_num[CW-1:0];
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign low_in = r_low[k-1];
                assign quo_in = r_quo[k-1];
            end

            always_comb begin
                trial    = {rem_in, low_in[CW-1]};
                fits     = (trial >= {1'b0, i_den});
                n_rem[k] = fits ? DW'(trial - {1'b0, i_den}) : trial[DW-1:0];
                n_low[k] = {low_in[CW-2:0], 1'b0};
                n_quo[k] = {quo_in[CW-2:0], fits};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem[k];
                    r_low[k] <= n_low[k];
                    r_quo[k] <= n_quo[k];
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[CW-1];

endmodule

// File: rtl/core/segment_nearest_point_unit.sv
// nearest point on a configured 2d segment, fully pipelined
//
// Usage: write start_x, start_y, end_x, end_y through the cfg channel
// (index 0..3) while no request is in flight; cfg is always ready. Query
// points enter on the s-side stream (tdata = point_x, point_y) and each
// produces exactly one result on the m-side stream (tdata = near_x,
// near_y; tuser = region: 0 start side or degenerate, 1 end side,
// 2 interior projection).
// Throughput: one request per cycle while the skid register is not full. The
// pipeline is an input register, six arithmetic stages (offset, products,
// dot sum, region decision, partial products, numerator sum), the divider,
// which resolves one quotient bit per stage over COORD_WIDTH stages, and the
// output register.
// Reset (synchronous, active low) clears the segment to zero and drops
// all requests in flight.
// When the receiver stalls, a skid register takes the next result and the
// input keeps being accepted; once the skid register is full the whole
// pipeline holds and o_s_tready goes low until the output is taken.
module segment_nearest_point_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // config write channel
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [snp_pkg::CFG_INDEX_WIDTH-1:0]          i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                       i_cfg_data,
    // query stream
    input  logic                                         i_s_tvalid,
    output logic                                         o_s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           i_s_tdata,  // point_x, point_y
    // result stream
    output logic                                         o_m_tvalid,
    input  logic                                         i_m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]           o_m_tdata,  // near_x, near_y
    output logic [1:0]                                   o_m_tuser   // region
);

    localparam int CW   = COORD_WIDTH;
    localparam int DXW  = CW + 1;
    localparam int PW   = 2 * CW + 2;
    localparam int DOTW = 2 * CW + 3;
    localparam int DDW  = 2 * CW + 1;
    localparam int NW   = 3 * CW + 1;
    localparam int TDW  = ((2 * CW + 7) / 8) * 8;

    // segment registers
    logic [CW-1:0] r_sx, r_sy, r_ex, r_ey;

    // values derived from the segment, registered after a write
    logic signed [DXW-1:0] r_dx, r_dy;
    logic [CW-1:0]         r_adx, r_ady;
    logic signed [PW-1:0]  r_sqx, r_sqy;
    logic [DDW-1:0]        r_dd;
    logic [PW-1:0]         dd_sum;

    // pipeline
    logic                  adv;
    logic                  r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic [CW-1:0]         r_px, r_py;
    logic signed [DXW-1:0] r_psx, r_psy;
    logic signed [PW-1:0]  r_mx, r_my;
    logic signed [DOTW-1:0] r_dot;
    snp_pkg::t_region      r_rg5, r_rg6, r_rg7;
    snp_pkg::t_region      n_rg5;
    logic [DDW-1:0]        r_t;
    logic [2*CW-1:0]       r_pxl, r_pyl;
    logic [2*CW:0]         r_pxh, r_pyh;
    logic [NW-1:0]         r_nx, r_ny;
    logic                  r_dv_v  [CW];
    snp_pkg::t_region      r_dv_rg [CW];
    logic [CW-1:0]         quo_x, quo_y;

    // result
    logic                  exit_v;
    snp_pkg::t_region      exit_rg;
    logic [CW-1:0]         exit_x, exit_y;
    logic [DXW-1:0]        sum_x, sum_y;
    logic                  out_fire;
    logic                  r_out_v, r_skid_v;
    logic [CW-1:0]         r_out_x, r_out_y, r_skid_x, r_skid_y;
    snp_pkg::t_region      r_out_rg, r_skid_rg;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                snp_pkg::CFG_START_X: r_sx <= i_cfg_data;
                snp_pkg::CFG_START_Y: r_sy <= i_cfg_data;
                snp_pkg::CFG_END_X:   r_ex <= i_cfg_data;
                snp_pkg::CFG_END_Y:   r_ey <= i_cfg_data;
            endcase
        end
    end

    assign dd_sum = r_sqx + r_sqy;

    // each of these is read only by stages an item reaches after they settle
    always_ff @(posedge i_clk) begin
        r_dx  <= {r_ex[CW-1], r_ex} - {r_sx[CW-1], r_sx};
        r_dy  <= {r_ey[CW-1], r_ey} - {r_sy[CW-1], r_sy};
        r_adx <= r_dx[DXW-1] ? CW'(-r_dx) : r_dx[CW-1:0];
        r_ady <= r_dy[DXW-1] ? CW'(-r_dy) : r_dy[CW-1:0];
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        r_dd  <= dd_sum[DDW-1:0];
    end

    // ---------------- pipeline control ----------------
    assign adv        = !r_skid_v;
    assign o_s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            for (int k = 0; k < CW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_dv_v[0] <= r_v7;
            for (int k = 1; k < CW; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
    end

    // region decision: dot(d, p - end) = dot(d, p - start) - dot(d, d)
    always_comb begin
        if (r_dot[DOTW-1] || (r_dd == '0)) begin
            n_rg5 = snp_pkg::REGION_START;
        end else if (r_dot[PW-1:0] > PW'(r_dd)) begin
            n_rg5 = snp_pkg::REGION_END;
        end else begin
            n_rg5 = snp_pkg::REGION_INTERIOR;
        end
    end

    // ---------------- pipeline data ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px  <= i_s_tdata[CW-1:0];
            r_py  <= i_s_tdata[2*CW-1:CW];
            r_psx <= {r_px[CW-1], r_px} - {r_sx[CW-1], r_sx};
            r_psy <= {r_py[CW-1], r_py} - {r_sy[CW-1], r_sy};
            r_mx  <= r_dx * r_psx;
            r_my  <= r_dy * r_psy;
            r_dot <= {r_mx[PW-1], r_mx} + {r_my[PW-1], r_my};
            r_rg5 <= n_rg5;
            r_t   <= r_dot[DDW-1:0];
            r_rg6 <= r_rg5;
            r_pxl <= r_adx * r_t[CW-1:0];
            r_pyl <= r_ady * r_t[CW-1:0];
            r_pxh <= r_adx * r_t[DDW-1:CW];
            r_pyh <= r_ady * r_t[DDW-1:CW];
            r_rg7 <= r_rg6;
            r_nx  <= {r_pxh, {CW{1'b0}}} + NW'(r_pxl);
            r_ny  <= {r_pyh, {CW{1'b0}}} + NW'(r_pyl);
            r_dv_rg[0] <= r_rg7;
            for (int k = 1; k < CW; k++) begin
                r_dv_rg[k] <= r_dv_rg[k-1];
            end
        end
    end

    snp_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_nx),
        .i_den (r_dd),
        .o_quo (quo_x)
    );

    snp_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_ny),
        .i_den (r_dd),
        .o_quo (quo_y)
    );

    // quotient sign follows the direction component
    assign sum_x = {r_sx[CW-1], r_sx} + (r_dx[DXW-1] ? -{1'b0, quo_x} : {1'b0, quo_x});
    assign sum_y = {r_sy[CW-1], r_sy} + (r_dy[DXW-1] ? -{1'b0, quo_y} : {1'b0, quo_y});

    assign exit_v  = r_dv_v[CW-1];
    assign exit_rg = r_dv_rg[CW-1];

    always_comb begin
        unique case (exit_rg)
            snp_pkg::REGION_START: begin
                exit_x = r_sx;
                exit_y = r_sy;
            end
            snp_pkg::REGION_END: begin
                exit_x = r_ex;
                exit_y = r_ey;
            end
            default: begin
                exit_x = sum_x[CW-1:0];
                exit_y = sum_y[CW-1:0];
            end
        endcase
    end

    // ---------------- output register and skid ----------------
    assign out_fire = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_fire) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (exit_v) begin
            if (!r_out_v || out_fire) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_fire) begin
                r_out_x  <= r_skid_x;
                r_out_y  <= r_skid_y;
                r_out_rg <= r_skid_rg;
            end
        end else if (exit_v) begin
            if (!r_out_v || out_fire) begin
                r_out_x  <= exit_x;
                r_out_y  <= exit_y;
                r_out_rg <= exit_rg;
            end else begin
                r_skid_x  <= exit_x;
                r_skid_y  <= exit_y;
                r_skid_rg <= exit_rg;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = TDW'({r_out_y, r_out_x});
    assign o_m_tuser  = r_out_rg;

endmodule

// File: sim/tb_segment_nearest_point_unit.sv
// self-checking testbench for the segment nearest point unit
module tb_segment_nearest_point_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_WIDTH = 16;
    localparam int LATENCY     = COORD_WIDTH + 7;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 250;

    typedef struct {
        logic [15:0]      x;
        logic [15:0]      y;
        snp_pkg::t_region region;
    } t_near_point;

    // keeps its own copy of the segment and predicts one nearest point per request
    class nearest_point_scoreboard;
        logic signed [15:0] seg_sx = '0;
        logic signed [15:0] seg_sy = '0;
        logic signed [15:0] seg_ex = '0;
        logic signed [15:0] seg_ey = '0;
        t_near_point        expected_q[$];
        int                 error_count = 0;

        function void set_register(logic [snp_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
            case (idx)
                snp_pkg::CFG_START_X: seg_sx = val;
                snp_pkg::CFG_START_Y: seg_sy = val;
                snp_pkg::CFG_END_X:   seg_ex = val;
                snp_pkg::CFG_END_Y:   seg_ey = val;
                default: ;
            endcase
        endfunction

        function void note_query(logic [31:0] tdata);
            longint      px, py, sx, sy, ex, ey, dx, dy, dot_s, dot_e, dd;
            t_near_point exp_pt;
            px = $signed(tdata[15:0]);
            py = $signed(tdata[31:16]);
            sx = seg_sx;
            sy = seg_sy;
            ex = seg_ex;
            ey = seg_ey;
            dx = ex - sx;
            dy = ey - sy;
            dot_s = dx * (px - sx) + dy * (py - sy);
            dot_e = dx * (px - ex) + dy * (py - ey);
            dd    = dx * dx + dy * dy;
            if (dot_s < 0 || dd == 0) begin
                exp_pt.x = seg_sx;
                exp_pt.y = seg_sy;
                exp_pt.region = snp_pkg::REGION_START;
            end else if (dot_e > 0) begin
                exp_pt.x = seg_ex;
                exp_pt.y = seg_ey;
                exp_pt.region = snp_pkg::REGION_END;
            end else begin
                // signed division truncates toward zero, as required
                exp_pt.x = 16'(sx + (dx * dot_s) / dd);
                exp_pt.y = 16'(sy + (dy * dot_s) / dd);
                exp_pt.region = snp_pkg::REGION_INTERIOR;
            end
            expected_q.push_back(exp_pt);
        endfunction

        function void check_result(logic [31:0] tdata, logic [1:0] tuser);
            t_near_point exp_pt;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request pending: x %0d y %0d region %0d",
                         $time, $signed(tdata[15:0]), $signed(tdata[31:16]), tuser);
                error_count++;
                return;
            end
            exp_pt = expected_q.pop_front();
            if (tdata[15:0] !== exp_pt.x) begin
                $display("%0t: near_x expected %0d actual %0d", $time,
                         $signed(exp_pt.x), $signed(tdata[15:0]));
                error_count++;
            end
            if (tdata[31:16] !== exp_pt.y) begin
                $display("%0t: near_y expected %0d actual %0d", $time,
                         $signed(exp_pt.y), $signed(tdata[31:16]));
                error_count++;
            end
            if (tuser !== exp_pt.region) begin
                $display("%0t: region expected %0d actual %0d", $time, exp_pt.region, tuser);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [snp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [COORD_WIDTH-1:0]              i_cfg_data;
    logic                                i_s_tvalid;
    logic                                o_s_tready;
    logic [31:0]                         i_s_tdata;   // point_x, point_y
    logic                                o_m_tvalid;
    logic                                i_m_tready;
    logic [31:0]                         o_m_tdata;   // near_x, near_y
    logic [1:0]                          o_m_tuser;   // region

    nearest_point_scoreboard sb = new;

    int unsigned       cycle_count = 0;
    int                src_idle_pct = 0;
    int                sink_stall_pct = 0;
    bit                hold_pending = 1'b0;
    logic signed [15:0] cur_sx, cur_sy, cur_ex, cur_ey;

    segment_nearest_point_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // accepted requests and results, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready === 1'b1) begin
            sb.note_query(i_s_tdata);
        end
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            sb.check_result(o_m_tdata, o_m_tuser);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin src_idle_pct = 59; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 59; end
            3:       begin src_idle_pct = 28; sink_stall_pct = 28; end
            default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    task automatic send_query(input logic signed [15:0] px, input logic signed [15:0] py);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [snp_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_register(idx, val);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // segment is only rewritten once every result is back
    task automatic program_segment(input logic signed [15:0] sx, input logic signed [15:0] sy,
                                   input logic signed [15:0] ex, input logic signed [15:0] ey);
        i_s_tvalid <= 1'b0;
        wait_drained();
        write_register(snp_pkg::CFG_START_X, sx);
        write_register(snp_pkg::CFG_START_Y, sy);
        write_register(snp_pkg::CFG_END_X, ex);
        write_register(snp_pkg::CFG_END_Y, ey);
        i_cfg_valid <= 1'b0;
        cur_sx = sx;
        cur_sy = sy;
        cur_ex = ex;
        cur_ey = ey;
    endtask

    // mostly points along the extended segment so that all three regions show up
    function automatic logic [31:0] pick_query();
        int     sel;
        longint t, bx, by;
        sel = $urandom_range(9);
        if (sel < 3) begin
            return $urandom();
        end else if (sel < 8) begin
            t  = longint'($urandom_range(384)) - 64;
            bx = cur_sx + ((longint'(cur_ex) - cur_sx) * t) / 256
                 + longint'($urandom_range(64)) - 32;
            by = cur_sy + ((longint'(cur_ey) - cur_sy) * t) / 256
                 + longint'($urandom_range(64)) - 32;
        end else if (sel == 8) begin
            bx = cur_sx + longint'($urandom_range(4)) - 2;
            by = cur_sy + longint'($urandom_range(4)) - 2;
        end else begin
            bx = cur_ex + longint'($urandom_range(4)) - 2;
            by = cur_ey + longint'($urandom_range(4)) - 2;
        end
        return {by[15:0], bx[15:0]};
    endfunction

    task automatic run_random_phase(input int kind, input bit hold);
        logic signed [15:0] sx, sy, ex, ey;
        logic [31:0]        q;
        sx = 16'($urandom());
        sy = 16'($urandom());
        ex = 16'($urandom());
        ey = 16'($urandom());
        case (kind)
            1: begin
                ex = 16'(sx + $signed(16'($urandom_range(512))) - 256);
                ey = 16'(sy + $signed(16'($urandom_range(512))) - 256);
            end
            2: begin
                if ($urandom_range(1)) begin
                    sx = -32768; sy = -32768; ex = 32767; ey = 32767;
                end else begin
                    sx = 32767; sy = -32768; ex = -32768; ey = 32767;
                end
            end
            3: begin
                ex = sx;
                ey = sy;
            end
            4: begin
                if ($urandom_range(1)) ey = sy;
                else ex = sx;
            end
            default: ;
        endcase
        program_segment(sx, sy, ex, ey);
        // long hold-off starts while the sender keeps offering requests
        if (hold) hold_pending = 1'b1;
        repeat (PHASE_ITEMS) begin
            q = pick_query();
            send_query(q[15:0], q[31:16]);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        cur_sx = '0;
        cur_sy = '0;
        cur_ex = '0;
        cur_ey = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset segment is degenerate at the origin
        set_idling(0);
        send_query(0, 0);
        send_query(32767, -32768);

        program_segment(-1600, -800, 4800, 3200);
        send_query(-1600, -800);
        send_query(4800, 3200);
        send_query(-3000, -3000);
        send_query(9000, 9000);
        send_query(1600, 1200);
        send_query(0, 4000);
        send_query(32767, 32767);
        send_query(-32768, -32768);
        send_query(-32768, 32767);

        // full-range diagonal
        program_segment(-32768, -32768, 32767, 32767);
        send_query(32767, -32768);
        send_query(-32768, 32767);
        send_query(0, 0);
        send_query(-32768, -32768);
        send_query(32767, 32767);
        send_query(12345, -2345);

        // vertical segment running downward
        program_segment(100, 32767, 100, -32768);
        send_query(-32768, 0);
        send_query(32767, -32768);
        send_query(5, 32767);

        // degenerate away from the origin
        program_segment(32767, -32768, 32767, -32768);
        send_query(0, 0);
        send_query(-32768, 32767);

        for (int ph = 0; ph < 7; ph++) begin
            set_idling(ph % 4);
            run_random_phase(ph % 5, ph == 0);
        end

        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/snp_pkg.sv
rtl/core/snp_div.sv
rtl/core/segment_nearest_point_unit.sv
sim/tb_segment_nearest_point_unit.sv
